### src/mcp_pkg.sv
// Shared types and constants for the Monte Carlo call payoff accumulator.
`default_nettype none
package mcp_pkg;

    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               last_path;
    } in_t;

    typedef struct packed {
        logic [62:0] payoff_sum;
        logic [31:0] path_total;
    } out_t;

    typedef struct packed {
        logic [23:0]        spot_price;
        logic [23:0]        strike_price;
        logic signed [24:0] log_drift;
        logic [22:0]        log_vol;
    } cfg_t;

    // reduced exponent handed from front to back
    typedef struct packed {
        logic [31:0] frac;
        logic [8:0]  quo;
        logic        last_path;
    } job_t;

    typedef enum logic [1:0] {
        CFG_SPOT   = 2'd0,
        CFG_STRIKE = 2'd1,
        CFG_DRIFT  = 2'd2,
        CFG_VOL    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_PROD,
        B_PRICE,
        B_ACC
    } back_state_t;

    localparam logic [40:0]        LN2_Q32    = 41'd2977044472;
    localparam logic [40:0]        X_OFFSET   = 41'd762123384832;  // 256 * LN2
    localparam logic [12:0]        RECIP_LN2  = 13'd5909;          // floor(2^44 / LN2)
    localparam logic [1:0]         RED_STEPS  = 2'd2;
    localparam logic signed [10:0] SHIFT_BIAS = 11'sd288;          // 32 + 256
    localparam logic [3:0]         EXP_TERMS  = 4'd12;
    localparam logic [1:0]         DIV_LAST   = 2'd3;
    localparam logic [32:0]        ONE_Q32    = 33'h1_0000_0000;
    localparam logic [62:0]        SUM_MAX    = '1;
    localparam logic [31:0]        PRICE_MAX  = '1;

    localparam logic [23:0] SPOT_RESET   = 24'd6553600;
    localparam logic [23:0] STRIKE_RESET = 24'd6553600;

endpackage
`default_nettype wire

### src/mc_call_payoff_accumulator.sv
// Top level of the Monte Carlo European call payoff accumulator.
// Usage:
//   s_* carries one item per path: a Q4.12 normal draw and a last_path flag.
//   m_* returns one item per batch (on last_path): the saturating Q47.16
//   payoff sum and the path count; the sum and count then clear.
//   cfg_* writes spot, strike, drift and vol by index; write only when idle.
// Operation:
//   The front end takes an item, forms the exponent and reduces it by ln2
//   with a reciprocal multiply, a back-multiply and one correction; it
//   takes a new item only after the current one is pushed to the queue.
//   The back end runs a 12-term exp series on one shared multiplier and an
//   8-bit-per-cycle divider, then price and payoff; it works on one item at
//   a time, and its pass over an item sets sustained throughput.
//   A two-entry queue lets the front take items while the back is busy.
// Reset: registers return to spot = strike = 100.0, drift = vol = 0; the
//   running sum and count clear. No clearing pass.
// Stall: a result waits in the output register; the back end holds only
//   when it must emit a new result while the old one is still pending.
`default_nettype none
module mc_call_payoff_accumulator (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mcp_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mcp_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [24:0]   cfg_data
);
    import mcp_pkg::*;

    cfg_t cfg_reg;
    logic push, full, pop, empty;
    job_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spot_price   <= SPOT_RESET;
            cfg_reg.strike_price <= STRIKE_RESET;
            cfg_reg.log_drift    <= '0;
            cfg_reg.log_vol      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPOT:   cfg_reg.spot_price   <= cfg_data[23:0];
                CFG_STRIKE: cfg_reg.strike_price <= cfg_data[23:0];
                CFG_DRIFT:  cfg_reg.log_drift    <= $signed(cfg_data);
                CFG_VOL:    cfg_reg.log_vol      <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    mcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mcp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

### src/mcp_front.sv
// Front end: accepts samples, forms the exponent and splits it into n*ln2 + r.
`default_nettype none
module mcp_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire mcp_pkg::cfg_t cfg,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire mcp_pkg::in_t s_data,
    output logic              push,
    output mcp_pkg::job_t     push_data,
    input  wire logic         full
);
    import mcp_pkg::*;

    front_state_t       state_reg, state_next;
    logic signed [15:0] z_reg;
    logic               last_reg;
    logic [40:0]        rem_reg;
    logic [8:0]         quo_reg;
    logic [1:0]         step_reg;

    logic signed [39:0] vol_term;
    logic signed [41:0] x_sum;
    logic [32:0]        q_scaled;
    logic [40:0]        q_back;
    logic               take;

    assign vol_term = $signed({1'b0, cfg.log_vol}) * z_reg;
    assign x_sum    = $signed({{5{cfg.log_drift[24]}}, cfg.log_drift, 12'd0})
                    + $signed({{2{vol_term[39]}}, vol_term})
                    + $signed({1'b0, X_OFFSET});
    // quotient estimate is exact or one low
    assign q_scaled = rem_reg[40:20] * RECIP_LN2;
    assign q_back   = quo_reg * LN2_Q32;
    assign take     = (rem_reg >= LN2_Q32);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_valid) state_next = F_MUL;
            F_MUL:  state_next = F_DIV;
            F_DIV:  if (step_reg == 2'd0) state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        push    = 1'b0;
        unique case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            F_PUSH:  push = !full;
            default: ;
        endcase
    end

    assign push_data.frac      = rem_reg[31:0];
    assign push_data.quo       = quo_reg;
    assign push_data.last_path = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    z_reg    <= s_data.normal_sample;
                    last_reg <= s_data.last_path;
                end
            end
            F_MUL: begin
                rem_reg  <= x_sum[40:0];
                quo_reg  <= '0;
                step_reg <= RED_STEPS;
            end
            F_DIV: begin
                case (step_reg)
                    2'd2: quo_reg <= q_scaled[32:24];
                    2'd1: rem_reg <= rem_reg - q_back;
                    2'd0: begin
                        if (take) begin
                            rem_reg <= rem_reg - LN2_Q32;
                            quo_reg <= quo_reg + 9'd1;
                        end
                    end
                    default: ;
                endcase
                step_reg <= step_reg - 2'd1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### src/mcp_queue.sv
// Two-entry queue between front and back ends.
`default_nettype none
module mcp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire mcp_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output mcp_pkg::job_t      pop_data,
    output logic               empty
);
    import mcp_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

### src/mcp_back.sv
// Back end: exp series, price scaling, payoff and saturating accumulation.
`default_nettype none
module mcp_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mcp_pkg::cfg_t cfg,
    input  wire logic          empty,
    input  wire mcp_pkg::job_t pop_data,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mcp_pkg::out_t      m_data
);
    import mcp_pkg::*;

    back_state_t state_reg, state_next;
    logic [31:0] r_reg;
    logic [8:0]  quo_reg;
    logic        last_reg;
    logic [32:0] term_reg;
    logic [33:0] esum_reg;
    logic [3:0]  k_reg;
    logic [31:0] div_reg;
    logic [31:0] dq_reg;
    logic [3:0]  drem_reg;
    logic [1:0]  dcnt_reg;
    logic [57:0] prod_reg;
    logic [31:0] price_reg;
    logic [62:0] acc_reg;
    logic [31:0] cnt_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic [64:0] mul_full;
    logic [7:0]  qbits;
    logic [3:0]  rem_out;
    logic [31:0] dq_new;
    logic        out_free;
    logic        acc_done;

    logic signed [10:0] shift_amt;
    logic [10:0]        lshift;
    logic [5:0]         rsh;
    logic [63:0]        prod_w;
    logic [63:0]        shifted;
    logic [31:0]        price_calc;

    logic [31:0] payoff;
    logic [63:0] sum_wide;
    logic [62:0] sum_sat;
    logic [31:0] cnt_inc;

    assign mul_full = term_reg * r_reg;

    // eight bits of long division by k per cycle
    always_comb begin
        logic [4:0] tmp;
        logic [3:0] rem;
        rem = drem_reg;
        for (int i = 0; i < 8; i++) begin
            tmp = {rem, div_reg[31 - i]};
            if (tmp >= {1'b0, k_reg}) begin
                tmp          = tmp - {1'b0, k_reg};
                qbits[7 - i] = 1'b1;
            end else begin
                qbits[7 - i] = 1'b0;
            end
            rem = tmp[3:0];
        end
        rem_out = rem;
    end
    assign dq_new = {dq_reg[23:0], qbits};

    assign shift_amt = SHIFT_BIAS - $signed({2'b00, quo_reg});
    assign lshift    = 11'd0 - shift_amt;
    assign rsh       = shift_amt[5:0];
    assign prod_w    = {6'd0, prod_reg};

    always_comb begin
        shifted    = '0;
        price_calc = '0;
        if (prod_reg == '0 || shift_amt >= 11'sd64) begin
            price_calc = '0;
        end else if (shift_amt > 11'sd0) begin
            shifted    = (prod_w + (64'd1 << (rsh - 6'd1))) >> rsh;
            price_calc = (shifted > {32'd0, PRICE_MAX}) ? PRICE_MAX : shifted[31:0];
        end else if (lshift >= 11'd8) begin
            price_calc = PRICE_MAX;
        end else begin
            shifted    = prod_w << lshift[2:0];
            price_calc = (shifted > {32'd0, PRICE_MAX}) ? PRICE_MAX : shifted[31:0];
        end
    end

    assign payoff   = (price_reg > {8'd0, cfg.strike_price})
                    ? price_reg - {8'd0, cfg.strike_price} : 32'd0;
    assign sum_wide = {1'b0, acc_reg} + {32'd0, payoff};
    assign sum_sat  = sum_wide[63] ? SUM_MAX : sum_wide[62:0];
    assign cnt_inc  = cnt_reg + 32'd1;
    assign out_free = !out_valid_reg || m_ready;
    assign acc_done = (state_reg == B_ACC) && (!last_reg || out_free);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!empty) state_next = B_MUL;
            B_MUL:   state_next = B_DIV;
            B_DIV: begin
                if (dcnt_reg == DIV_LAST) begin
                    state_next = (k_reg == EXP_TERMS) ? B_PROD : B_MUL;
                end
            end
            B_PROD:  state_next = B_PRICE;
            B_PRICE: state_next = B_ACC;
            B_ACC:   if (acc_done) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop = !empty;
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (acc_done) begin
                if (last_reg) begin
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    acc_reg <= sum_sat;
                    cnt_reg <= cnt_inc;
                end
            end
            if (acc_done && last_reg) out_valid_reg <= 1'b1;
            else if (m_ready)         out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                r_reg    <= pop_data.frac;
                quo_reg  <= pop_data.quo;
                last_reg <= pop_data.last_path;
                term_reg <= ONE_Q32;
                esum_reg <= {1'b0, ONE_Q32};
                k_reg    <= 4'd1;
            end
            B_MUL: begin
                div_reg  <= mul_full[63:32];
                dq_reg   <= '0;
                drem_reg <= '0;
                dcnt_reg <= '0;
            end
            B_DIV: begin
                div_reg  <= {div_reg[23:0], 8'd0};
                dq_reg   <= dq_new;
                drem_reg <= rem_out;
                dcnt_reg <= dcnt_reg + 2'd1;
                if (dcnt_reg == DIV_LAST) begin
                    term_reg <= {1'b0, dq_new};
                    esum_reg <= esum_reg + {2'b00, dq_new};
                    k_reg    <= k_reg + 4'd1;
                end
            end
            B_PROD:  prod_reg  <= cfg.spot_price * esum_reg;
            B_PRICE: price_reg <= price_calc;
            B_ACC: begin
                if (acc_done && last_reg) begin
                    out_reg.payoff_sum <= sum_sat;
                    out_reg.path_total <= cnt_inc;
                end
            end
            default: ;
        endcase
    end

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_MUL |-> (k_reg >= 4'd1 && k_reg <= EXP_TERMS))
        else $error("series index out of range");

    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_done && last_reg |=> out_valid_reg && acc_reg == '0 && cnt_reg == '0)
        else $error("batch close did not emit and clear");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the Monte Carlo call payoff accumulator: self-predicting, randomized.
`timescale 1ns / 1ps
module tb;
    import mcp_pkg::*;

    localparam longint      LN2_FIX    = 64'd2977044472;
    localparam longint unsigned SUM_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned PRICE_TOP = 64'hFFFF_FFFF;
    localparam int          STALL_LIMIT = 4000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0]  cfg_index = CFG_SPOT;
    logic [24:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    mc_call_payoff_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of registers and batch state
    logic [23:0]        spot_r   = SPOT_RESET;
    logic [23:0]        strike_r = STRIKE_RESET;
    logic signed [24:0] drift_r  = '0;
    logic [22:0]        vol_r    = '0;
    longint unsigned    batch_sum = 0;
    logic [31:0]        batch_paths = '0;
    out_t               batch_q[$];

    int  errors = 0;
    bit  calm = 1'b0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    function automatic longint unsigned call_payoff(logic signed [15:0] z);
        longint x, n, s;
        longint unsigned r, e, term, prod, price;
        x = longint'(drift_r) * 4096 + longint'(vol_r) * longint'(z);
        n = (x >= 0) ? x / LN2_FIX : -((-x + LN2_FIX - 1) / LN2_FIX);
        r = x - n * LN2_FIX;
        e = 64'd1 << 32;
        term = e;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * r) >> 32) / k;
            e += term;
        end
        prod = longint'(spot_r) * e;
        s = 32 - n;
        if (prod == 0 || s >= 64) begin
            price = 0;
        end else if (s > 0) begin
            price = (prod + (64'd1 << (s - 1))) >> s;
        end else if (-s >= 8) begin
            price = PRICE_TOP;
        end else begin
            price = prod << (-s);
        end
        if (price > PRICE_TOP) price = PRICE_TOP;
        return (price > strike_r) ? price - strike_r : 0;
    endfunction

    task automatic add_path(logic signed [15:0] z, logic last);
        longint unsigned p;
        out_t o;
        p = call_payoff(z);
        batch_sum = (p > SUM_TOP - batch_sum) ? SUM_TOP : batch_sum + p;
        batch_paths = batch_paths + 1;
        if (last) begin
            o.payoff_sum = batch_sum[62:0];
            o.path_total = batch_paths;
            batch_q.push_back(o);
            batch_sum = 0;
            batch_paths = '0;
        end
    endtask

    task automatic send_item(logic signed [15:0] z, logic last);
        if (!calm && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.normal_sample <= z;
        s_data.last_path <= last;
        do @(posedge aclk); while (!s_ready);
        add_path(z, last);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (batch_q.size() == 0);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [24:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SPOT:   spot_r = val[23:0];
            CFG_STRIKE: strike_r = val[23:0];
            CFG_DRIFT:  drift_r = val;
            CFG_VOL:    vol_r = val[22:0];
        endcase
    endtask

    task automatic load_market(logic [23:0] sp, logic [23:0] sk, logic signed [24:0] dr,
                               logic [22:0] vo);
        write_reg(CFG_SPOT, {1'b0, sp});
        write_reg(CFG_STRIKE, {1'b0, sk});
        write_reg(CFG_DRIFT, dr);
        write_reg(CFG_VOL, {2'b0, vo});
        @(posedge aclk);
    endtask

    task automatic test_directed();
        // reset values: spot = strike, zero exponent, payoff zero
        send_item(16'sd0, 1'b1);
        drain();
        load_market(24'd6553600, 24'd3276800, 25'sd0, 23'd262144);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd32767, 1'b0);
        send_item(16'sd4096, 1'b1);
        drain();
        // huge exponent saturates price; very negative rounds to zero
        load_market(24'hFFFFFF, 24'd0, 25'sh0FFFFFF, 23'h7FFFFF);
        send_item(16'sd32767, 1'b0);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd0, 1'b1);
        drain();
        load_market(24'd0, 24'hFFFFFF, -25'sd16777216, 23'd4194304);
        send_item(16'sd32767, 1'b0);
        send_item(-16'sd1, 1'b1);
        drain();
        load_market(24'd1, 24'd0, -25'sd16777216, 23'd0);
        send_item(16'sd100, 1'b1);
        send_item(16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_random();
        int batch;
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            load_market(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                        (ph == 5) ? 25'($urandom) : 25'($signed($urandom_range(400000)) - 200000),
                        (ph == 6) ? 23'($urandom) : 23'($urandom_range(500000)));
            batch = 0;
            for (int i = 0; i < 135; i++) begin
                batch++;
                send_item(16'($urandom), (batch >= 12) || ($urandom_range(9) == 0));
                if (s_data.last_path) batch = 0;
            end
            send_item(16'($urandom), 1'b1);
            drain();
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        load_market(24'd6553600, 24'd5898240, 25'sd10000, 23'd209715);
        hold_cycles = 600;
        for (int i = 0; i < 40; i++) send_item(16'($urandom), (i % 3) == 2);
        drain();
    endtask

    // receiver side
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (batch_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item sum=%0d paths=%0d",
                                           m_data.payoff_sum, m_data.path_total);
            end else begin
                if (m_data !== batch_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp sum=%0d paths=%0d got sum=%0d paths=%0d",
                                 batch_q[0].payoff_sum, batch_q[0].path_total,
                                 m_data.payoff_sum, m_data.path_total);
                end
                void'(batch_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        if (errors == 0 && batch_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### filelist.f
src/mcp_pkg.sv
src/mcp_front.sv
src/mcp_queue.sv
src/mcp_back.sv
src/mc_call_payoff_accumulator.sv
tb/tb.sv
